FILE: rtl/spq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the stable priority request queue.
// No dependencies; every other file of the block imports this package.
package spq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned PRIO_W    = 16;
  localparam int unsigned TAG_W     = 16;
  localparam int unsigned OCC_W     = 5;
  localparam int unsigned TOTAL_W   = 32;

  typedef enum logic [1:0] {
    FUNC_ENQ  = 2'd0,
    FUNC_DEQ  = 2'd1,
    FUNC_STOP = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_STOPPED = 2'd3
  } status_e;

  // Input beat.
  typedef struct packed {
    logic [1:0]               func;
    logic signed [PRIO_W-1:0] req_priority;
    logic [TAG_W-1:0]         req_tag;
  } in_t;

  // Output beat.
  typedef struct packed {
    logic [1:0]               status;
    logic                     out_valid;
    logic [TAG_W-1:0]         out_tag;
    logic signed [PRIO_W-1:0] out_priority;
    logic [OCC_W-1:0]         occupancy;
    logic                     is_stopped;
    logic [TOTAL_W-1:0]       enqueued_total;
    logic [TOTAL_W-1:0]       processed_total;
  } out_t;

  // Contents of one queue cell.
  typedef struct packed {
    logic                     occ;
    logic signed [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]         tag;
  } entry_t;

  // Command broadcast to every cell in a cycle.
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage

FILE: rtl/spq_cell.sv
`timescale 1ns / 1ps
// One cell of the sorted shift-register queue: holds a single entry.
// Depends on spq_pkg for the entry and command types.
module spq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::entry_t    new_i,
  input  spq_pkg::entry_t    left_i,
  input  logic               left_ins_i,
  input  spq_pkg::entry_t    right_i,
  output logic               ins_o,
  output spq_pkg::entry_t    q_o
);
  import spq_pkg::*;

  entry_t entry_d, entry_q;

  // The new entry belongs at or before this cell when this cell is free or
  // holds a strictly lower priority; equal priorities keep their place.
  assign ins_o = !entry_q.occ || ($signed(entry_q.prio) < $signed(new_i.prio));

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.enq && ins_o) begin
      entry_d = left_ins_i ? left_i : new_i;
    end else if (ctrl_i.deq) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign q_o = entry_q;

endmodule

FILE: rtl/stable_priority_request_queue_top.sv
`timescale 1ns / 1ps
// Each result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while the output side takes results, since
// every cell compares against the new priority in parallel and shifts at once.
// Reset (rst_ni, asynchronous, active low) empties the queue, clears every
// cell, the stop flag and both totals.
// Depends on spq_pkg and spq_cell.
module stable_priority_request_queue_top #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  spq_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output spq_pkg::out_t  out_data_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // Queue state outside the cell row.
  logic [CntW-1:0]    count_d, count_q;
  logic               stop_d, stop_q;
  logic [TOTAL_W-1:0] enq_tot_d, enq_tot_q;
  logic [TOTAL_W-1:0] deq_tot_d, deq_tot_q;

  // Result register; it parts the input side from the output side.
  logic ovld_q;
  out_t res_d, res_q;

  logic       accept;
  logic       full, empty;
  cell_ctrl_t ctrl;
  entry_t     new_entry;
  entry_t     cell_q [DEPTH];
  logic       cell_ins [DEPTH];

  // A new beat is taken whenever the result register is free or drains now.
  assign in_ready_o = !ovld_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign full  = (count_q == CntW'(DEPTH));
  assign empty = (count_q == '0);

  assign new_entry.occ  = 1'b1;
  assign new_entry.prio = in_data_i.req_priority;
  assign new_entry.tag  = in_data_i.req_tag;

  // Decode the beat and build its result from the state before it.
  always_comb begin
    ctrl      = '0;
    stop_d    = stop_q;
    count_d   = count_q;
    enq_tot_d = enq_tot_q;
    deq_tot_d = deq_tot_q;
    res_d     = '0;
    res_d.status = ST_OK;
    case (in_data_i.func)
      FUNC_ENQ: begin
        if (stop_q) begin
          res_d.status = ST_STOPPED;
        end else if (full) begin
          res_d.status = ST_FULL;
        end else begin
          ctrl.enq  = accept;
          count_d   = count_q + CntW'(1);
          enq_tot_d = enq_tot_q + TOTAL_W'(1);
        end
      end
      FUNC_DEQ: begin
        if (empty) begin
          res_d.status = ST_EMPTY;
        end else begin
          ctrl.deq           = accept;
          res_d.out_valid    = 1'b1;
          res_d.out_tag      = cell_q[0].tag;
          res_d.out_priority = cell_q[0].prio;
          count_d            = count_q - CntW'(1);
          deq_tot_d          = deq_tot_q + TOTAL_W'(1);
        end
      end
      FUNC_STOP: begin
        stop_d = 1'b1;
      end
      default: begin
        // Unused code: nothing changes, the current state is reported.
      end
    endcase
    res_d.occupancy       = OCC_W'(count_d);
    res_d.is_stopped      = stop_d;
    res_d.enqueued_total  = enq_tot_d;
    res_d.processed_total = deq_tot_d;
  end

  // The row of cells: slot 0 holds the entry served next. An enqueue moves
  // every lower-priority entry one cell back; a dequeue moves all forward.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_ins;
    if (i == 0) begin : g_head
      assign left_e   = '0;
      assign left_ins = 1'b0;
    end else begin : g_body
      assign left_e   = cell_q[i-1];
      assign left_ins = cell_ins[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_mid
      assign right_e = cell_q[i+1];
    end
    spq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .new_i      (new_entry),
      .left_i     (left_e),
      .left_ins_i (left_ins),
      .right_i    (right_e),
      .ins_o      (cell_ins[i]),
      .q_o        (cell_q[i])
    );
  end

  // State registers advance only on an accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      stop_q    <= 1'b0;
      enq_tot_q <= '0;
      deq_tot_q <= '0;
    end else if (accept) begin
      count_q   <= count_d;
      stop_q    <= stop_d;
      enq_tot_q <= enq_tot_d;
      deq_tot_q <= deq_tot_d;
    end
  end

  // Output valid holds until the beat is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (in_ready_o) begin
      ovld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = ovld_q;
  assign out_data_o  = res_q;

endmodule

FILE: rtl/spq_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the stable priority request queue, with its bind.
// Depends on spq_pkg and stable_priority_request_queue_top.
module spq_chk #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input spq_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input spq_pkg::out_t out_data_o
);
  import spq_pkg::*;

  logic               out_beat;
  logic               seen_stop_q;
  logic               seen_beat_q;
  logic [TOTAL_W-1:0] last_enq_q;

  assign out_beat = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_stop_q <= 1'b0;
      seen_beat_q <= 1'b0;
      last_enq_q  <= '0;
    end else if (out_beat) begin
      seen_stop_q <= seen_stop_q || out_data_o.is_stopped;
      seen_beat_q <= 1'b1;
      last_enq_q  <= out_data_o.enqueued_total;
    end
  end

  // A dequeued entry is only reported with an ok status.
  a_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && out_data_o.out_valid |-> out_data_o.status == ST_OK)
    else $error("dequeued entry reported with a failing status");

  // An empty report leaves an empty queue.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && out_data_o.status == ST_EMPTY |->
      out_data_o.occupancy == '0 && !out_data_o.out_valid)
    else $error("empty status with entries present");

  // Once stopped, the block stays stopped.
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && seen_stop_q |-> out_data_o.is_stopped)
    else $error("stop flag dropped");

  // The enqueue total advances by at most one per beat.
  a_enq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && seen_beat_q |->
      out_data_o.enqueued_total == last_enq_q ||
      out_data_o.enqueued_total == last_enq_q + TOTAL_W'(1))
    else $error("enqueue total jumped");

  // The reported occupancy never exceeds the queue depth.
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> 32'(out_data_o.occupancy) <= DEPTH)
    else $error("occupancy above the queue depth");

endmodule

bind stable_priority_request_queue_top spq_chk #(.DEPTH(DEPTH)) u_spq_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
